// ----- src/go_back_n_sender_macros.svh -----
// Assertion macros shared by the go-back-n sender RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GBN_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("go_back_n_sender: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define GBN_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("go_back_n_sender: assertion failed");

`endif

// ----- src/gbn_pkg.sv -----
// Types and constants of the go-back-n sender.
// No dependencies; used by the interfaces, controller, datapath, top level and testbench.
package gbn_pkg;

    localparam int CMD_W    = 2;
    localparam int AKIND_W  = 4;
    localparam int SEQ_W    = 13;
    localparam int CHUNK_W  = 9;
    localparam int WIN_W    = 6;
    localparam int TOTAL_W  = 14;
    localparam int TRY_W    = 4;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int MAX_WINDOW  = 32;
    localparam int MAX_MESSAGE = 8192;

    localparam logic [AKIND_W-1:0] ACK_KIND_ACK = 4'd2;

    localparam logic [CHUNK_W-1:0] RST_CHUNK  = 9'd64;
    localparam logic [WIN_W-1:0]   RST_WINDOW = 6'd4;
    localparam logic [TOTAL_W-1:0] RST_TOTAL  = 14'd8192;
    localparam logic [TRY_W-1:0]   RST_TRY    = 4'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_TEAR = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2,
        PH_FAILED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SETUP,
        S_SEND,
        S_TEAR,
        S_FAIL
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK  = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_TOTAL  = 2'd2,
        CFG_TRY    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [WIN_W-1:0]   window_packets;
        logic [TOTAL_W-1:0] total_bytes;
        logic [TRY_W-1:0]   try_limit;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic start;
        logic ack_take;
        logic tick_take;
        logic win_setup;
        logic load_data;
        logic load_tear;
        logic load_fail;
        logic tear_last;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic ack_ok;
        logic ack_final;
        logic ack_resend;
        logic tick_fail;
        logic div_done;
        logic pt_zero;
        logic data_last;
        logic slot_free;
    } t_dp_sts;

endpackage

// ----- src/gbn_in_if.sv -----
// Input channel of the go-back-n sender: commands and received acks.
// Depends on gbn_pkg.
interface gbn_in_if;
    import gbn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [AKIND_W-1:0]   ack_kind;
    logic [SEQ_W-1:0]     ack_number;

    modport source(output valid, command, ack_kind, ack_number, input ready);
    modport sink(input valid, command, ack_kind, ack_number, output ready);
endinterface

// ----- src/gbn_out_if.sv -----
// Output channel of the go-back-n sender: packet descriptors and failure.
// Depends on gbn_pkg.
interface gbn_out_if;
    import gbn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     offset;
    logic [CHUNK_W-1:0]   length;
    logic                 last;

    modport source(output valid, kind, seq, offset, length, last, input ready);
    modport sink(input valid, kind, seq, offset, length, last, output ready);
endinterface

// ----- src/gbn_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the datapath for the packet count.
module gbn_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= (DEN_W+1)'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - (DEN_W+1)'(r_den)) : w_trial;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ----- src/gbn_ctrl.sv -----
// Controller state machine of the go-back-n sender.
// Depends on gbn_pkg and go_back_n_sender_macros.svh; drives gbn_dpath.
`include "go_back_n_sender_macros.svh"

module gbn_ctrl #(
    parameter int TEARDOWN_COUNT = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gbn_pkg::t_dp_sts  i_sts,
    output gbn_pkg::t_dp_cmd  o_cmd
);
    import gbn_pkg::*;

    localparam int TC_W = (TEARDOWN_COUNT > 1) ? $clog2(TEARDOWN_COUNT) : 1;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [TC_W-1:0] r_tear_cnt, n_tear_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_tear_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_tear_cnt <= n_tear_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_tear_cnt = r_tear_cnt;
        o_cmd      = '0;
        o_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                case (i_sts.cmd)
                    CMD_START: begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_ACTIVE;
                        n_state     = S_DIV;
                    end
                    CMD_ACK: begin
                        if (r_phase == PH_ACTIVE && i_sts.ack_ok) begin
                            o_cmd.ack_take = 1'b1;
                            if (i_sts.ack_final) begin
                                n_phase    = PH_DONE;
                                n_tear_cnt = '0;
                                n_state    = S_TEAR;
                            end else if (i_sts.ack_resend) begin
                                n_state = S_SETUP;
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (r_phase == PH_ACTIVE) begin
                            o_cmd.tick_take = 1'b1;
                            if (i_sts.tick_fail) begin
                                n_phase = PH_FAILED;
                                n_state = S_FAIL;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.pt_zero) begin
                        n_phase    = PH_DONE;
                        n_tear_cnt = '0;
                        n_state    = S_TEAR;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.win_setup = 1'b1;
                n_state         = S_SEND;
            end
            S_SEND: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_sts.data_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TEAR: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_tear = 1'b1;
                    o_cmd.tear_last = (r_tear_cnt == TC_W'(TEARDOWN_COUNT - 1));
                    n_tear_cnt      = r_tear_cnt + TC_W'(1);
                    if (o_cmd.tear_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FAIL: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_fail = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `GBN_ASSERT_IMPL(a_data_only_active, i_clk, i_rst_n, o_cmd.load_data, r_state == S_SEND && r_phase == PH_ACTIVE)
    `GBN_ASSERT_NEXT(a_fail_ends, i_clk, i_rst_n, r_state == S_FAIL && i_sts.slot_free, r_state == S_IDLE && r_phase == PH_FAILED)
    `GBN_ASSERT_NEXT(a_tear_ends, i_clk, i_rst_n, o_cmd.load_tear && o_cmd.tear_last, r_state == S_IDLE && r_phase == PH_DONE)
endmodule

// ----- src/gbn_dpath.sv -----
// Datapath of the go-back-n sender: window state, descriptor arithmetic
// and the output register. Depends on gbn_pkg, gbn_div, gbn_out_if.
`include "go_back_n_sender_macros.svh"

module gbn_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbn_pkg::t_cfg               i_cfg,
    input  logic [gbn_pkg::CMD_W-1:0]   i_command,
    input  logic [gbn_pkg::AKIND_W-1:0] i_ack_kind,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_number,
    input  gbn_pkg::t_dp_cmd            i_cmd,
    output gbn_pkg::t_dp_sts            o_sts,
    gbn_out_if.source                   o_out
);
    import gbn_pkg::*;

    // Captured input word.
    t_cmd                r_cmd;
    logic [AKIND_W-1:0]  r_akind;
    logic [SEQ_W-1:0]    r_anum;

    // Transfer state.
    logic [CHUNK_W-1:0]        r_chunk;
    logic [TOTAL_W-1:0]        r_total;
    logic [TOTAL_W-1:0]        r_pt;
    logic [SEQ_W-1:0]          r_base;
    logic signed [TOTAL_W-1:0] r_hs;
    logic signed [TOTAL_W-1:0] r_ha;
    logic [TRY_W-1:0]          r_tc;

    // Burst walk.
    logic [SEQ_W-1:0]    r_seq;
    logic [SEQ_W-1:0]    r_off;
    logic [TOTAL_W-1:0]  r_end;

    // Output register.
    logic                r_out_valid;
    t_kind               r_kind;
    logic [SEQ_W-1:0]    r_oseq;
    logic [SEQ_W-1:0]    r_ooff;
    logic [CHUNK_W-1:0]  r_olen;
    logic                r_olast;

    logic [CHUNK_W-1:0]        w_eff_chunk;
    logic [TOTAL_W-1:0]        w_eff_total;
    logic [TOTAL_W-1:0]        w_div_num;
    logic                      w_div_done;
    logic [TOTAL_W-1:0]        w_quot;
    logic [WIN_W-1:0]          w_win;
    logic [TOTAL_W-1:0]        w_endp;
    logic [TOTAL_W-1:0]        w_end_excl;
    logic signed [TOTAL_W-1:0] w_end_m1;
    logic [SEQ_W+CHUNK_W-1:0]  w_prod;
    logic [TOTAL_W-1:0]        w_rem;
    logic [CHUNK_W-1:0]        w_len;
    logic signed [TOTAL_W-1:0] w_ha_n;
    logic [TRY_W-1:0]          w_tc_n;
    logic                      w_slot_free;
    logic                      w_load_any;

    assign w_eff_chunk = (i_cfg.chunk_bytes == '0) ? CHUNK_W'(1) : i_cfg.chunk_bytes;
    assign w_eff_total = (i_cfg.total_bytes > TOTAL_W'(MAX_MESSAGE)) ?
                         TOTAL_W'(MAX_MESSAGE) : i_cfg.total_bytes;
    assign w_div_num   = w_eff_total + TOTAL_W'(w_eff_chunk) - TOTAL_W'(1);

    gbn_div #(
        .NUM_W(TOTAL_W),
        .DEN_W(CHUNK_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.start),
        .i_num  (w_div_num),
        .i_den  (w_eff_chunk),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_comb begin
        if (i_cfg.window_packets == '0) begin
            w_win = WIN_W'(1);
        end else if (i_cfg.window_packets > WIN_W'(MAX_WINDOW)) begin
            w_win = WIN_W'(MAX_WINDOW);
        end else begin
            w_win = i_cfg.window_packets;
        end
    end

    // The burst runs from base up to the smaller of base plus window and
    // the packet count; the highest sent number can only grow.
    assign w_endp     = TOTAL_W'(r_base) + TOTAL_W'(w_win);
    assign w_end_excl = (w_endp < r_pt) ? w_endp : r_pt;
    assign w_end_m1   = $signed(w_end_excl - TOTAL_W'(1));
    assign w_prod     = (SEQ_W+CHUNK_W)'(r_base) * (SEQ_W+CHUNK_W)'(r_chunk);

    // The last chunk carries what is left of the message.
    assign w_rem = r_total - TOTAL_W'(r_off);
    assign w_len = (w_rem >= TOTAL_W'(r_chunk)) ? r_chunk : w_rem[CHUNK_W-1:0];

    assign w_ha_n = r_ha + TOTAL_W'(1);
    assign w_tc_n = r_tc + TRY_W'(1);

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_load_any  = i_cmd.load_data || i_cmd.load_tear || i_cmd.load_fail;

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_cmd;
        o_sts.ack_ok     = (r_akind == ACK_KIND_ACK) &&
                           ($signed({1'b0, r_anum}) > r_ha);
        o_sts.ack_final  = $unsigned(w_ha_n) >= (r_pt - TOTAL_W'(1));
        o_sts.ack_resend = (w_ha_n == r_hs);
        o_sts.tick_fail  = (w_tc_n >= i_cfg.try_limit);
        o_sts.div_done   = w_div_done;
        o_sts.pt_zero    = (w_quot == '0);
        o_sts.data_last  = ((TOTAL_W'(r_seq) + TOTAL_W'(1)) == r_end);
        o_sts.slot_free  = w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_NONE;
            r_pt        <= '0;
            r_base      <= '0;
            r_hs        <= '1;
            r_ha        <= '1;
            r_tc        <= '0;
            r_chunk     <= RST_CHUNK;
            r_total     <= RST_TOTAL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cmd <= t_cmd'(i_command);
            end
            if (i_cmd.start) begin
                r_chunk <= w_eff_chunk;
                r_total <= w_eff_total;
                r_base  <= '0;
                r_hs    <= '1;
                r_ha    <= '1;
                r_tc    <= '0;
            end
            if (w_div_done) begin
                r_pt <= w_quot;
            end
            if (i_cmd.ack_take) begin
                r_ha   <= w_ha_n;
                r_tc   <= '0;
                r_base <= SEQ_W'(w_ha_n + TOTAL_W'(1));
            end
            if (i_cmd.tick_take) begin
                r_tc <= w_tc_n;
            end
            if (i_cmd.win_setup && (w_end_m1 > r_hs)) begin
                r_hs <= w_end_m1;
            end
            if (w_load_any) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_akind <= i_ack_kind;
            r_anum  <= i_ack_number;
        end
        if (i_cmd.win_setup) begin
            r_seq <= r_base;
            r_off <= w_prod[SEQ_W-1:0];
            r_end <= w_end_excl;
        end else if (i_cmd.load_data) begin
            r_seq <= r_seq + SEQ_W'(1);
            r_off <= r_off + SEQ_W'(r_chunk);
        end
        if (i_cmd.load_data) begin
            r_kind  <= KIND_DATA;
            r_oseq  <= r_seq;
            r_ooff  <= r_off;
            r_olen  <= w_len;
            r_olast <= o_sts.data_last;
        end else if (i_cmd.load_tear || i_cmd.load_fail) begin
            r_kind  <= i_cmd.load_tear ? KIND_TEAR : KIND_FAIL;
            r_oseq  <= '0;
            r_ooff  <= '0;
            r_olen  <= '0;
            r_olast <= i_cmd.load_fail || i_cmd.tear_last;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.kind   = r_kind;
    assign o_out.seq    = r_oseq;
    assign o_out.offset = r_ooff;
    assign o_out.length = r_olen;
    assign o_out.last   = r_olast;

    `GBN_ASSERT_IMPL(a_hs_bound, i_clk, i_rst_n, !r_hs[TOTAL_W-1], $unsigned(r_hs) < r_pt)
    `GBN_ASSERT_IMPL(a_seq_bound, i_clk, i_rst_n, i_cmd.load_data, TOTAL_W'(r_seq) < r_end && r_end <= r_pt)
    `GBN_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_load_any, !r_out_valid || o_out.ready)
endmodule

// ----- src/go_back_n_sender.sv -----
// Go-back-n ARQ sender control: accepts start, ack and timeout words and
// emits packet descriptor words (sequence, byte offset, length), teardown
// words and a failure word.
//
// The input channel takes one word while the block is idle; a word that is
// ignored (unknown command, ack or tick outside a transfer, stale ack) only
// passes through evaluation back to idle. An ack or tick that resends a
// window passes through evaluation and window setup before its first
// descriptor is loaded; a start runs the packet-count divider (one quotient
// bit per cycle) before window setup, or before teardown for an empty
// message. After that one descriptor leaves per cycle from a single output
// register while the receiver holds ready high. The word after the final
// descriptor of an item is taken once the burst has been loaded.
// Reset clears the transfer to idle with the register defaults (chunk 64,
// window 4, message 8192 bytes, try limit 10). When the receiver holds
// ready low the output word stays and the burst pauses; nothing is dropped.
// Configuration writes take effect at once and belong in idle periods.
module go_back_n_sender #(
    parameter int TEARDOWN_COUNT = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gbn_in_if.sink                         i_in,
    gbn_out_if.source                      o_out
);
    import gbn_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_bytes    <= RST_CHUNK;
            r_cfg.window_packets <= RST_WINDOW;
            r_cfg.total_bytes    <= RST_TOTAL;
            r_cfg.try_limit      <= RST_TRY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHUNK:  r_cfg.chunk_bytes    <= i_cfg_data[CHUNK_W-1:0];
                CFG_WINDOW: r_cfg.window_packets <= i_cfg_data[WIN_W-1:0];
                CFG_TOTAL:  r_cfg.total_bytes    <= i_cfg_data[TOTAL_W-1:0];
                CFG_TRY:    r_cfg.try_limit      <= i_cfg_data[TRY_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    gbn_ctrl #(
        .TEARDOWN_COUNT(TEARDOWN_COUNT)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .o_ready(w_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    gbn_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_command   (i_in.command),
        .i_ack_kind  (i_in.ack_kind),
        .i_ack_number(i_in.ack_number),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

    assign i_in.ready = w_ready;
endmodule

// ----- test/go_back_n_sender_tb.sv -----
// Testbench of the go-back-n sender: directed and random start, ack and timeout words
// with random idling and back-pressure, each descriptor word checked against a predictor.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if and go_back_n_sender.
module go_back_n_sender_tb;
    import gbn_pkg::*;

    localparam int TEARDOWN_WORDS = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   offset;
        logic [CHUNK_W-1:0] length;
        logic               last;
    } t_desc;

    class gbn_tx_model;
        logic [CHUNK_W-1:0] chunk_reg;
        logic [WIN_W-1:0]   window_reg;
        logic [TOTAL_W-1:0] total_reg;
        logic [TRY_W-1:0]   try_reg;
        logic [SEQ_W-1:0]   base;
        logic [TRY_W-1:0]   timeouts;
        int                 sent_hi;
        int                 acked_hi;
        int                 pkt_total;
        int                 chunk_eff;
        int                 total_eff;
        t_phase             xfer_phase;
        t_desc              burst[$];
        t_desc              due_words[$];
        int                 errors;

        function new();
            chunk_reg  = RST_CHUNK;
            window_reg = RST_WINDOW;
            total_reg  = RST_TOTAL;
            try_reg    = RST_TRY;
            base       = '0;
            timeouts   = '0;
            sent_hi    = -1;
            acked_hi   = -1;
            pkt_total  = 0;
            chunk_eff  = int'(RST_CHUNK);
            total_eff  = int'(RST_TOTAL);
            xfer_phase = PH_IDLE;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CHUNK:  chunk_reg  = data[CHUNK_W-1:0];
                CFG_WINDOW: window_reg = data[WIN_W-1:0];
                CFG_TOTAL:  total_reg  = data[TOTAL_W-1:0];
                CFG_TRY:    try_reg    = data[TRY_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_desc(t_kind k, int s, int off, int len);
            t_desc d;
            d.kind   = k;
            d.seq    = s[SEQ_W-1:0];
            d.offset = off[SEQ_W-1:0];
            d.length = len[CHUNK_W-1:0];
            d.last   = 1'b0;
            burst.push_back(d);
        endfunction

        function void emit_window();
            int win;
            int s;
            int off;
            int len;
            win = (window_reg == 0) ? 1 : int'(window_reg);
            if (win > MAX_WINDOW) win = MAX_WINDOW;
            for (int c = 0; c < win; c++) begin
                s = int'(base) + c;
                if (s > sent_hi) sent_hi = s;
                if (sent_hi > pkt_total - 1) sent_hi = pkt_total - 1;
                if (s < pkt_total) begin
                    off = s * chunk_eff;
                    len = (total_eff - off >= chunk_eff) ? chunk_eff : total_eff % chunk_eff;
                    add_desc(KIND_DATA, s, off, len);
                end
            end
        endfunction

        function void emit_teardown();
            repeat (TEARDOWN_WORDS) add_desc(KIND_TEAR, 0, 0, 0);
            xfer_phase = PH_DONE;
        endfunction

        // Returns 1 when the word changed the transfer rather than being dropped.
        function bit take_word(t_cmd cmd, logic [AKIND_W-1:0] akind, logic [SEQ_W-1:0] anum);
            bit acted;
            acted = 1'b0;
            burst.delete();
            case (cmd)
                CMD_START: begin
                    acted      = 1'b1;
                    chunk_eff  = (chunk_reg == 0) ? 1 : int'(chunk_reg);
                    total_eff  = (total_reg > MAX_MESSAGE) ? MAX_MESSAGE : int'(total_reg);
                    pkt_total  = (total_eff + chunk_eff - 1) / chunk_eff;
                    base       = '0;
                    sent_hi    = -1;
                    acked_hi   = -1;
                    timeouts   = '0;
                    xfer_phase = PH_ACTIVE;
                    if (pkt_total == 0) emit_teardown();
                    else emit_window();
                end
                CMD_ACK: begin
                    if (xfer_phase == PH_ACTIVE && akind == ACK_KIND_ACK
                            && int'(anum) > acked_hi) begin
                        acted = 1'b1;
                        acked_hi++;
                        timeouts = '0;
                        if (acked_hi >= pkt_total - 1) begin
                            emit_teardown();
                        end else begin
                            base = acked_hi[SEQ_W-1:0] + 1'b1;
                            if (acked_hi == sent_hi) emit_window();
                        end
                    end
                end
                CMD_TICK: begin
                    if (xfer_phase == PH_ACTIVE) begin
                        acted    = 1'b1;
                        timeouts = timeouts + 1'b1;
                        if (timeouts >= try_reg) begin
                            add_desc(KIND_FAIL, 0, 0, 0);
                            xfer_phase = PH_FAILED;
                        end else begin
                            emit_window();
                        end
                    end
                end
                default: ;
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) due_words.push_back(burst[i]);
            return acted;
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_word(t_desc got);
            t_desc want;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: word expected none, got kind %0d seq %0d offset %0d length %0d",
                         $time, got.kind, got.seq, got.offset, got.length);
                return;
            end
            want = due_words.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("seq", want.seq, got.seq);
            check_field("offset", want.offset, got.offset);
            check_field("length", want.length, got.length);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gbn_in_if  in_ch ();
    gbn_out_if out_ch ();

    gbn_tx_model tx_model = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_done    = 0;
    int stall_count   = 0;

    go_back_n_sender #(
        .TEARDOWN_COUNT(TEARDOWN_WORDS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_desc seen;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.kind   = t_kind'(out_ch.kind);
            seen.seq    = out_ch.seq;
            seen.offset = out_ch.offset;
            seen.length = out_ch.length;
            seen.last   = out_ch.last;
            tx_model.match_word(seen);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, logic [AKIND_W-1:0] akind, logic [SEQ_W-1:0] anum);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.ack_kind   <= akind;
        in_ch.ack_number <= anum;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        void'(tx_model.take_word(cmd, akind, anum));
        items_done++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tx_model.due_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tx_model.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] chunk, logic [CFG_DATA_W-1:0] win,
                               logic [CFG_DATA_W-1:0] total, logic [CFG_DATA_W-1:0] tries);
        put_reg(CFG_CHUNK, chunk);
        put_reg(CFG_WINDOW, win);
        put_reg(CFG_TOTAL, total);
        put_reg(CFG_TRY, tries);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_transfer(int budget);
        int roll;
        int num;
        int k;
        num = $urandom_range(8191);
        k   = $urandom_range(15);
        send_word(CMD_START, k[AKIND_W-1:0], num[SEQ_W-1:0]);
        while (budget > 0 && tx_model.xfer_phase == PH_ACTIVE) begin
            budget--;
            roll = $urandom_range(99);
            num  = $urandom_range(8191);
            k    = $urandom_range(15);
            if (roll < 62) begin
                if (roll < 54) num = tx_model.acked_hi + 1;
                else num = $urandom_range(8191, tx_model.acked_hi + 1);
                send_word(CMD_ACK, ACK_KIND_ACK, num[SEQ_W-1:0]);
            end else if (roll < 76) begin
                send_word(CMD_TICK, k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end else if (roll < 84) begin
                if (k == ACK_KIND_ACK) k++;
                send_word(CMD_ACK, k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end else if (roll < 89 && tx_model.acked_hi >= 0) begin
                num = $urandom_range(tx_model.acked_hi);
                send_word(CMD_ACK, ACK_KIND_ACK, num[SEQ_W-1:0]);
            end else if (roll < 92) begin
                send_word(CMD_NONE, k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end else if (roll < 95) begin
                send_word(CMD_START, k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end else begin
                roll = $urandom_range(3);
                send_word(t_cmd'(roll[CMD_W-1:0]), k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end
        end
    endtask

    task automatic random_phase(int goal);
        int roll;
        int c;
        int ce;
        int span;
        int t;
        int w;
        int r;
        int stop_at;
        int num;
        int k;
        roll = $urandom_range(9);
        c    = (roll == 0) ? 0 : (roll == 1) ? 511 : $urandom_range(511, 1);
        ce   = (c == 0) ? 1 : c;
        roll = $urandom_range(11);
        if (roll == 0) begin
            t = 0;
        end else if (roll == 1 && ce >= 256) begin
            t = $urandom_range(16383, MAX_MESSAGE);
        end else begin
            span = ce * $urandom_range(30, 1);
            if (span > MAX_MESSAGE) span = MAX_MESSAGE;
            t = $urandom_range(span, 1);
        end
        roll = $urandom_range(9);
        w    = (roll == 0) ? 0 : (roll == 1) ? MAX_WINDOW
             : (roll == 2) ? $urandom_range(63, MAX_WINDOW + 1) : $urandom_range(MAX_WINDOW, 1);
        roll = $urandom_range(9);
        r    = (roll == 0) ? 0 : (roll == 1) ? 15 : $urandom_range(14, 3);
        load_config(c[CFG_DATA_W-1:0], w[CFG_DATA_W-1:0], t[CFG_DATA_W-1:0],
                    r[CFG_DATA_W-1:0]);
        stop_at = items_done + goal;
        while (items_done < stop_at) begin
            run_transfer(100);
            if ($urandom_range(3) == 0) begin
                num  = $urandom_range(8191);
                k    = $urandom_range(15);
                roll = $urandom_range(CMD_TICK, CMD_ACK);
                send_word(t_cmd'(roll[CMD_W-1:0]), k[AKIND_W-1:0], num[SEQ_W-1:0]);
            end
        end
        drain();
    endtask

    initial begin
        int num;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_CHUNK;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_NONE;
        in_ch.ack_kind   = '0;
        in_ch.ack_number = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 75;

        // Reset defaults: words outside a transfer, stale and foreign acks, resend, restart.
        send_word(CMD_TICK, 4'd0, 13'd0);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd0);
        send_word(CMD_NONE, 4'd15, 13'd8191);
        send_word(CMD_START, 4'd15, 13'd8191);
        send_word(CMD_ACK, 4'd0, 13'd5);
        send_word(CMD_ACK, 4'd15, 13'd8191);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd0);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd0);
        send_word(CMD_TICK, 4'd0, 13'd0);
        repeat (4) send_word(CMD_ACK, ACK_KIND_ACK, 13'd8191);
        send_word(CMD_NONE, 4'd0, 13'd0);
        send_word(CMD_START, 4'd0, 13'd0);
        drain();

        // Empty message with zero chunk, zero window and zero try limit.
        load_config(14'd0, 14'd0, 14'd0, 14'd0);
        send_word(CMD_START, 4'd0, 13'd0);
        send_word(CMD_TICK, 4'd0, 13'd0);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd1);
        send_word(CMD_START, 4'd0, 13'd0);
        drain();

        // Oversized message, largest chunk, window above the limit, failure on first tick.
        load_config(14'd511, 14'd63, 14'd16383, 14'd0);
        send_word(CMD_START, 4'd0, 13'd0);
        send_word(CMD_TICK, 4'd0, 13'd0);
        send_word(CMD_TICK, 4'd0, 13'd0);
        send_word(CMD_START, 4'd0, 13'd0);
        drain();

        load_config(14'd1, 14'd32, 14'd3, 14'd15);
        send_word(CMD_START, 4'd0, 13'd0);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd0);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd1);
        send_word(CMD_ACK, ACK_KIND_ACK, 13'd2);
        drain();

        while (items_done < 160) random_phase(45);

        send_idle_pct = 75;
        recv_idle_pct = 25;
        while (items_done < 310) random_phase(45);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // The receiver stalls while full windows keep coming, then the sender waits it out.
        load_config(14'd1, 14'd32, 14'd200, 14'd15);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        send_word(CMD_START, 4'd0, 13'd0);
        repeat (5) send_word(CMD_TICK, 4'd0, 13'd0);
        in_ch.valid <= 1'b0;
        while (tx_model.due_words.size() != 0) @(negedge i_clk);
        repeat (40) begin
            num = tx_model.acked_hi + 1;
            send_word(CMD_ACK, ACK_KIND_ACK, num[SEQ_W-1:0]);
        end
        drain();

        while (items_done < 460) random_phase(45);

        if (tx_model.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/gbn_pkg.sv
src/gbn_in_if.sv
src/gbn_out_if.sv
src/gbn_div.sv
src/gbn_ctrl.sv
src/gbn_dpath.sv
src/go_back_n_sender.sv
test/go_back_n_sender_tb.sv
